>>> hdl/mpool_pkg.sv
// Shared types and constants for the 3x3 stride-2 max pooling core.
// Holds the window entry, result tag and register index definitions.
// No dependencies.
`default_nettype none

package mpool_pkg;

    localparam int MAX_HEIGHT   = 256;
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_CHANNELS = 64;
    localparam int VALUE_BITS   = 16;

    localparam int BAND_DEPTH = MAX_WIDTH / 2;
    localparam int BAND_AW    = $clog2(BAND_DEPTH);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_HEIGHT  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic [8:0] RESET_HEIGHT   = 9'd224;
    localparam logic [8:0] RESET_WIDTH    = 9'd224;
    localparam logic [6:0] RESET_CHANNELS = 7'd64;

    // Window position offsets: column inside a row, and row base.
    localparam logic [3:0] POS_COL_LEFT  = 4'd0;
    localparam logic [3:0] POS_COL_MID   = 4'd1;
    localparam logic [3:0] POS_COL_RIGHT = 4'd2;
    localparam logic [3:0] POS_ROW_MID   = 4'd3;
    localparam logic [3:0] POS_ROW_LOW   = 4'd6;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] value;
        logic [3:0]                   pos;
    } t_entry;

    typedef struct packed {
        logic [5:0] channel;
        logic [6:0] row;
        logic [6:0] col;
        logic       last;
    } t_tag;

    typedef struct packed {
        t_entry entry;
        t_tag   tag;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/mpool_cell.sv
// Compare-and-hold cell: keeps the running maximum and its window position.
// One cell does the row pass, a second one the column pass. Uses mpool_pkg.
`default_nettype none

module mpool_cell (
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic              i_first,
    input  wire mpool_pkg::t_entry i_cand,
    input  wire mpool_pkg::t_entry i_prev,
    output mpool_pkg::t_entry      o_next,
    output mpool_pkg::t_entry      o_held
);
    import mpool_pkg::*;

    t_entry r_held;

    // A later candidate only wins when strictly greater, so the earliest
    // position keeps a tie.
    always_comb begin
        if (i_first || (i_cand.value > i_prev.value)) begin
            o_next = i_cand;
        end else begin
            o_next = i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_held <= o_next;
        end
    end

    assign o_held = r_held;

endmodule

`default_nettype wire

>>> hdl/mpool_line_buf.sv
// Line buffer with one partial window result per output column.
// One write and one registered read per cycle. Uses mpool_pkg.
`default_nettype none

module mpool_line_buf (
    input  wire logic                         i_clk,
    input  wire logic                         i_we,
    input  wire logic [mpool_pkg::BAND_AW-1:0] i_waddr,
    input  wire mpool_pkg::t_entry            i_wdata,
    input  wire logic [mpool_pkg::BAND_AW-1:0] i_raddr,
    output mpool_pkg::t_entry                 o_rdata
);
    import mpool_pkg::*;

    t_entry r_mem [BAND_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/mpool_out_fifo.sv
// Small result queue between the pooling pipeline and the output channel.
// Reports its fill level so the input side can reserve room. Uses mpool_pkg.
`default_nettype none

module mpool_out_fifo (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire mpool_pkg::t_result            i_data,
    input  wire logic                          i_pop,
    output logic                               o_valid,
    output mpool_pkg::t_result                 o_data,
    output logic [mpool_pkg::FIFO_AW:0]        o_count
);
    import mpool_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> hdl/max_pool_3x3_stride2_argmax_core.sv
// 3x3 max pooling, stride 2, padding 1, with the argmax position (0..8, row-major,
// the first position wins ties) of every pooled value. Pixels arrive one per beat
// in channel, row, column order; the core takes one pixel per clock cycle unless
// o_ready stalls it. A row cell folds three columns into a row maximum, a column
// cell folds three row maxima through a 128-entry line buffer. A result passes the
// row cell, stage 2 and the column cell, then waits in a four-entry queue; the
// input stalls only when that queue plus the results still in the pipeline fill it.
// A height, width or channel-count write restarts at channel 0, row 0, column 0.
`default_nettype none

module max_pool_3x3_stride2_argmax_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [1:0]                          i_cfg_index,
    input  wire logic [8:0]                          i_cfg_data,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [mpool_pkg::VALUE_BITS-1:0] i_pixel_value,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [mpool_pkg::VALUE_BITS-1:0]  o_pooled_max,
    output logic [3:0]                               o_window_position,
    output logic [5:0]                               o_out_channel,
    output logic [6:0]                               o_out_row,
    output logic [6:0]                               o_out_col,
    output logic                                     o_last_of_map
);
    import mpool_pkg::*;

    // Configuration and raster position.
    logic [8:0] r_height;
    logic [8:0] r_width;
    logic [6:0] r_channels;
    logic [7:0] r_row;
    logic [7:0] r_col;
    logic [5:0] r_chan;

    logic [8:0] w_height;
    logic [8:0] w_width;
    logic [6:0] w_channels;
    logic [7:0] w_out_rows;
    logic [7:0] w_out_cols;
    logic       w_cfg_hit;
    logic       w_fire;
    logic       w_col_wrap;
    logic       w_row_wrap;
    logic       w_chan_wrap;
    logic       w_last;

    // Pipeline stages.
    logic signed [VALUE_BITS-1:0] r_carry;
    logic                 r_s1_valid;
    logic                 r_s1_odd;
    logic                 r_s1_first;
    logic [BAND_AW-1:0]   r_s1_ow;
    t_tag                 r_s1_tag;
    logic                 r_s2_valid;
    logic                 r_s2_odd;
    logic                 r_s2_first;
    logic [BAND_AW-1:0]   r_s2_ow;
    t_tag                 r_s2_tag;
    t_entry               r_s2_row;
    logic                 r_s3_valid;
    t_tag                 r_s3_tag;

    t_entry               w_row_cand;
    t_entry               w_row_prev;
    t_entry               w_row_next;
    t_entry               w_row_held;
    t_entry               w_col_cand;
    t_entry               w_col_next;
    t_entry               w_col_held;
    t_entry               w_buf_rdata;
    t_entry               w_buf_wdata;
    t_result              w_push_data;
    t_result              w_head;
    logic [FIFO_AW:0]     w_fifo_count;
    logic [2:0]           w_pending;
    logic                 w_pop;

    always_comb begin
        if (r_height < 9'd2) begin
            w_height = 9'd2;
        end else if (r_height > 9'(MAX_HEIGHT)) begin
            w_height = 9'(MAX_HEIGHT);
        end else begin
            w_height = r_height;
        end
        if (r_width < 9'd2) begin
            w_width = 9'd2;
        end else if (r_width > 9'(MAX_WIDTH)) begin
            w_width = 9'(MAX_WIDTH);
        end else begin
            w_width = r_width;
        end
        if (r_channels < 7'd1) begin
            w_channels = 7'd1;
        end else if (r_channels > 7'(MAX_CHANNELS)) begin
            w_channels = 7'(MAX_CHANNELS);
        end else begin
            w_channels = r_channels;
        end
    end

    assign w_out_rows = w_height[8:1];
    assign w_out_cols = w_width[8:1];

    assign w_cfg_hit = i_cfg_we && ((i_cfg_index == CFG_IMAGE_HEIGHT)
                                 || (i_cfg_index == CFG_IMAGE_WIDTH)
                                 || (i_cfg_index == CFG_CHANNEL_COUNT));

    assign w_fire      = i_valid && o_ready;
    assign w_col_wrap  = ({1'b0, r_col} + 9'd1) >= w_width;
    assign w_row_wrap  = ({1'b0, r_row} + 9'd1) >= w_height;
    assign w_chan_wrap = ({1'b0, r_chan} + 7'd1) >= w_channels;
    assign w_last = (({1'b0, r_chan} + 7'd1) == w_channels)
                 && (({1'b0, r_row[7:1]} + 8'd1) == w_out_rows)
                 && (({1'b0, r_col[7:1]} + 8'd1) == w_out_cols);

    // Keep room in the queue for every result still travelling down the pipe.
    assign w_pending = 3'(r_s1_valid && r_s1_odd) + 3'(r_s2_valid && r_s2_odd)
                     + 3'(r_s3_valid);
    assign o_ready = (4'(w_fifo_count) + 4'(w_pending)) < 4'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height   <= RESET_HEIGHT;
            r_width    <= RESET_WIDTH;
            r_channels <= RESET_CHANNELS;
            r_row      <= '0;
            r_col      <= '0;
            r_chan     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_HEIGHT:  r_height   <= i_cfg_data;
                    CFG_IMAGE_WIDTH:   r_width    <= i_cfg_data;
                    CFG_CHANNEL_COUNT: r_channels <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (w_cfg_hit) begin
                r_row  <= '0;
                r_col  <= '0;
                r_chan <= '0;
            end else if (w_fire) begin
                if (w_col_wrap) begin
                    r_col <= '0;
                    if (w_row_wrap) begin
                        r_row <= '0;
                        r_chan <= w_chan_wrap ? '0 : r_chan + 1'b1;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            // A row maximum is complete on every odd column.
            r_s1_valid <= w_fire && r_col[0];
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_carry <= i_pixel_value;
        end
        r_s1_odd         <= r_row[0];
        r_s1_first       <= (r_row == '0);
        r_s1_ow          <= r_col[7:1];
        r_s1_tag.channel <= r_chan;
        r_s1_tag.row     <= r_row[7:1];
        r_s1_tag.col     <= r_col[7:1];
        r_s1_tag.last    <= w_last;
        r_s2_odd         <= r_s1_odd;
        r_s2_first       <= r_s1_first;
        r_s2_ow          <= r_s1_ow;
        r_s2_tag         <= r_s1_tag;
        r_s2_row         <= w_row_held;
        r_s3_tag         <= r_s2_tag;
    end

    // Row cell: the middle column compares against the previous pixel, the
    // right column against the partial held in the cell.
    always_comb begin
        w_row_cand.value = i_pixel_value;
        w_row_cand.pos   = r_col[0] ? POS_COL_RIGHT : POS_COL_MID;
        if (r_col[0]) begin
            w_row_prev = w_row_held;
        end else begin
            w_row_prev.value = r_carry;
            w_row_prev.pos   = POS_COL_LEFT;
        end
    end

    mpool_cell u_row_cell (
        .i_clk   (i_clk),
        .i_load  (w_fire),
        .i_first (!r_col[0] && (r_col == '0)),
        .i_cand  (w_row_cand),
        .i_prev  (w_row_prev),
        .o_next  (w_row_next),
        .o_held  (w_row_held)
    );

    // Column cell: an even row is the middle of its window, an odd row the bottom.
    always_comb begin
        w_col_cand.value = r_s2_row.value;
        w_col_cand.pos   = r_s2_row.pos + (r_s2_odd ? POS_ROW_LOW : POS_ROW_MID);
        // An odd row also opens the next window as its top row.
        w_buf_wdata = r_s2_odd ? r_s2_row : w_col_next;
    end

    mpool_cell u_col_cell (
        .i_clk   (i_clk),
        .i_load  (r_s2_valid),
        .i_first (r_s2_first && !r_s2_odd),
        .i_cand  (w_col_cand),
        .i_prev  (w_buf_rdata),
        .o_next  (w_col_next),
        .o_held  (w_col_held)
    );

    mpool_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_we    (r_s2_valid),
        .i_waddr (r_s2_ow),
        .i_wdata (w_buf_wdata),
        .i_raddr (r_s1_ow),
        .o_rdata (w_buf_rdata)
    );

    assign w_push_data.entry = w_col_held;
    assign w_push_data.tag   = r_s3_tag;
    assign w_pop = o_valid && i_ready;

    mpool_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s3_valid),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (w_head),
        .o_count (w_fifo_count)
    );

    assign o_pooled_max      = w_head.entry.value;
    assign o_window_position = w_head.entry.pos;
    assign o_out_channel     = w_head.tag.channel;
    assign o_out_row         = w_head.tag.row;
    assign o_out_col         = w_head.tag.col;
    assign o_last_of_map     = w_head.tag.last;

endmodule

`default_nettype wire

>>> tb/sv/max_pool_3x3_stride2_argmax_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for max_pool_3x3_stride2_argmax_core: a directed table, then
// random feature maps of many shapes, checked beat by beat against a pooling predictor.
// Depends on mpool_pkg and the core RTL only.

module max_pool_3x3_stride2_argmax_core_tb;
    import mpool_pkg::*;

    localparam logic [1:0]  CFG_UNUSED     = 2'd3;
    localparam int          DIRECTED_ROWS  = 28;
    localparam int          RANDOM_ITEMS   = 170;
    localparam int          SETTLE_CYCLES  = 12;
    localparam int          HOLD_CYCLES    = 80;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    typedef struct packed {
        logic signed [VALUE_BITS-1:0] max_value;
        logic [3:0]                   position;
        logic [5:0]                   channel;
        logic [6:0]                   row;
        logic [6:0]                   col;
        logic                         last;
    } t_pool_result;

    typedef enum bit {ROW_WRITE, ROW_PIXEL} t_row_kind;

    typedef struct {
        t_row_kind                    kind;
        logic [1:0]                   reg_index;
        logic [8:0]                   reg_data;
        logic signed [VALUE_BITS-1:0] pixel;
        bit                           has_want;
        t_pool_result                 want;
    } t_directed_row;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_cfg_we = 1'b0;
    logic [1:0]                   i_cfg_index = CFG_IMAGE_HEIGHT;
    logic [8:0]                   i_cfg_data = '0;
    logic                         i_valid = 1'b0;
    logic                         o_ready;
    logic signed [VALUE_BITS-1:0] i_pixel_value = '0;
    logic                         o_valid;
    logic                         i_ready = 1'b0;
    logic signed [VALUE_BITS-1:0] o_pooled_max;
    logic [3:0]                   o_window_position;
    logic [5:0]                   o_out_channel;
    logic [6:0]                   o_out_row;
    logic [6:0]                   o_out_col;
    logic                         o_last_of_map;

    max_pool_3x3_stride2_argmax_core DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel_value     (i_pixel_value),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pooled_max      (o_pooled_max),
        .o_window_position (o_window_position),
        .o_out_channel     (o_out_channel),
        .o_out_row         (o_out_row),
        .o_out_col         (o_out_col),
        .o_last_of_map     (o_last_of_map)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    bit          idle_on = 1'b0;
    bit          hold_request = 1'b0;

    t_pool_result  pool_expect_q[$];
    t_pool_result  want_res;
    t_directed_row directed_rows [DIRECTED_ROWS];

    // Predictor state: shape registers, raster position and the two accumulator bands.
    logic [8:0]                   shape_height;
    logic [8:0]                   shape_width;
    logic [6:0]                   shape_channels;
    int unsigned                  scan_row;
    int unsigned                  scan_col;
    int unsigned                  scan_channel;
    logic signed [VALUE_BITS-1:0] band_max [2][BAND_DEPTH];
    logic [3:0]                   band_pos [2][BAND_DEPTH];

    function automatic int unsigned clamp_dim(input int unsigned x, input int unsigned lo,
                                              input int unsigned hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    function automatic int unsigned map_pixels();
        return clamp_dim(shape_height, 2, MAX_HEIGHT) * clamp_dim(shape_width, 2, MAX_WIDTH)
               * clamp_dim(shape_channels, 1, MAX_CHANNELS);
    endfunction

    function automatic void mirror_reg_write(input logic [1:0] idx, input logic [8:0] data);
        case (idx)
            CFG_IMAGE_HEIGHT: begin
                shape_height = data;
            end
            CFG_IMAGE_WIDTH: begin
                shape_width = data;
            end
            CFG_CHANNEL_COUNT: begin
                shape_channels = data[6:0];
            end
            default: begin
                return;
            end
        endcase
        scan_row = 0;
        scan_col = 0;
        scan_channel = 0;
    endfunction

    // Folds one pixel into every window it belongs to and reports the result, if any,
    // that this pixel closes.
    function automatic bit predict_pool_step(input logic signed [VALUE_BITS-1:0] v,
                                             output t_pool_result res);
        int unsigned h, w, ch, oh_n, ow_n, r, c, oh, ow;
        int unsigned rows_oh [2], rows_wr [2], cols_ow [2], cols_wc [2];
        int          nr, nc, i, j;
        bit          first_row, first_col, emit;
        h = clamp_dim(shape_height, 2, MAX_HEIGHT);
        w = clamp_dim(shape_width, 2, MAX_WIDTH);
        ch = clamp_dim(shape_channels, 1, MAX_CHANNELS);
        oh_n = h / 2;
        ow_n = w / 2;
        r = scan_row;
        c = scan_col;
        nr = 0;
        nc = 0;
        emit = 1'b0;
        res = '0;
        if (r % 2 == 0) begin
            if (r / 2 < oh_n) begin
                rows_oh[nr] = r / 2; rows_wr[nr] = 1; nr++;
            end
        end else begin
            if (r / 2 < oh_n) begin
                rows_oh[nr] = r / 2; rows_wr[nr] = 2; nr++;
            end
            if (r / 2 + 1 < oh_n) begin
                rows_oh[nr] = r / 2 + 1; rows_wr[nr] = 0; nr++;
            end
        end
        if (c % 2 == 0) begin
            if (c / 2 < ow_n) begin
                cols_ow[nc] = c / 2; cols_wc[nc] = 1; nc++;
            end
        end else begin
            if (c / 2 < ow_n) begin
                cols_ow[nc] = c / 2; cols_wc[nc] = 2; nc++;
            end
            if (c / 2 + 1 < ow_n) begin
                cols_ow[nc] = c / 2 + 1; cols_wc[nc] = 0; nc++;
            end
        end
        for (i = 0; i < nr; i++) begin
            for (j = 0; j < nc; j++) begin
                oh = rows_oh[i];
                ow = cols_ow[j];
                // The top or left padding makes window row or column 1 the first real one.
                first_row = (rows_wr[i] == 0) || (rows_wr[i] == 1 && oh == 0);
                first_col = (cols_wc[j] == 0) || (cols_wc[j] == 1 && ow == 0);
                if ((first_row && first_col) || v > band_max[oh % 2][ow]) begin
                    band_max[oh % 2][ow] = v;
                    band_pos[oh % 2][ow] = 4'(rows_wr[i] * 3 + cols_wc[j]);
                end
            end
        end
        if (r % 2 == 1 && c % 2 == 1 && r / 2 < oh_n && c / 2 < ow_n) begin
            oh = r / 2;
            ow = c / 2;
            res.max_value = band_max[oh % 2][ow];
            res.position = band_pos[oh % 2][ow];
            res.channel = 6'(scan_channel);
            res.row = 7'(oh);
            res.col = 7'(ow);
            res.last = (scan_channel + 1 == ch && oh + 1 == oh_n && ow + 1 == ow_n);
            emit = 1'b1;
        end
        scan_col++;
        if (scan_col >= w) begin
            scan_col = 0;
            scan_row++;
            if (scan_row >= h) begin
                scan_row = 0;
                scan_channel++;
                if (scan_channel >= ch) scan_channel = 0;
            end
        end
        return emit;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] random_pixel();
        int unsigned pick;
        pick = $urandom_range(0, 5);
        if (pick == 0) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        // Values close together make ties between window positions common.
        if (pick == 1) return 16'($urandom_range(0, 6)) - 16'd3;
        return 16'($urandom());
    endfunction

    function automatic t_directed_row write_row(input logic [1:0] idx, input logic [8:0] data);
        t_directed_row row;
        row = '{ROW_WRITE, idx, data, '0, 1'b0, '0};
        return row;
    endfunction

    function automatic t_directed_row pixel_row(input logic signed [VALUE_BITS-1:0] v);
        t_directed_row row;
        row = '{ROW_PIXEL, CFG_IMAGE_HEIGHT, '0, v, 1'b0, '0};
        return row;
    endfunction

    function automatic t_directed_row closing_row(input logic signed [VALUE_BITS-1:0] v,
                                                  input t_pool_result want);
        t_directed_row row;
        row = '{ROW_PIXEL, CFG_IMAGE_HEIGHT, '0, v, 1'b1, want};
        return row;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) $display("ERROR cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        mirror_reg_write(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_map_shape(input logic [8:0] hd, input logic [8:0] wd,
                                 input logic [8:0] cd);
        write_reg(CFG_IMAGE_HEIGHT, hd);
        write_reg(CFG_IMAGE_WIDTH, wd);
        write_reg(CFG_CHANNEL_COUNT, cd);
    endtask

    // Entered and left at a falling edge; valid stays up between back-to-back beats.
    task automatic push_pixel(input logic signed [VALUE_BITS-1:0] v, input bit has_want,
                              input t_pool_result want);
        int           gap;
        bit           emitted;
        t_pool_result predicted;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 5);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_value <= v;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        emitted = predict_pool_step(v, predicted);
        if (has_want) pool_expect_q.push_back(want);
        else if (emitted) pool_expect_q.push_back(predicted);
        @(negedge i_clk);
    endtask

    task automatic run_map(input int unsigned count);
        int unsigned n;
        for (n = 0; n < count; n++) push_pixel(random_pixel(), 1'b0, '0);
    endtask

    // Pixels that close no window may still be in flight, so allow the pipeline to empty.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pool_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Output side: random back-pressure, plus one long hold-off on request.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pool_expect_q.size() == 0) begin
                report_mismatch($sformatf("result beat with none expected: ch %0d row %0d col %0d",
                                          o_out_channel, o_out_row, o_out_col));
            end else begin
                want_res = pool_expect_q.pop_front();
                if (o_pooled_max !== want_res.max_value)
                    report_mismatch($sformatf("pooled_max %0d, expected %0d",
                                              o_pooled_max, want_res.max_value));
                if (o_window_position !== want_res.position)
                    report_mismatch($sformatf("window_position %0d, expected %0d",
                                              o_window_position, want_res.position));
                if (o_out_channel !== want_res.channel)
                    report_mismatch($sformatf("out_channel %0d, expected %0d",
                                              o_out_channel, want_res.channel));
                if (o_out_row !== want_res.row)
                    report_mismatch($sformatf("out_row %0d, expected %0d",
                                              o_out_row, want_res.row));
                if (o_out_col !== want_res.col)
                    report_mismatch($sformatf("out_col %0d, expected %0d",
                                              o_out_col, want_res.col));
                if (o_last_of_map !== want_res.last)
                    report_mismatch($sformatf("last_of_map %0d, expected %0d",
                                              o_last_of_map, want_res.last));
            end
        end
    end

    initial begin
        int unsigned k, count, random_items;
        logic [8:0]  hd, wd, cd;
        shape_height = RESET_HEIGHT;
        shape_width = RESET_WIDTH;
        shape_channels = RESET_CHANNELS;
        scan_row = 0;
        scan_col = 0;
        scan_channel = 0;

        // Height 0 saturates to 2 and width 3 leaves an unused right column; the channel
        // count keeps its reset value until the later write of 0x180, which masks to 0
        // and saturates to a single channel.
        directed_rows = '{
            write_row(CFG_IMAGE_HEIGHT, 9'd0),
            write_row(CFG_IMAGE_WIDTH, 9'd3),
            pixel_row(16'sh8000), pixel_row(16'sh8000), pixel_row(16'sh7FFF),
            pixel_row(16'sh8000),
            closing_row(16'sh8000, t_pool_result'{16'sh8000, 4'd4, 6'd0, 7'd0, 7'd0, 1'b0}),
            pixel_row(16'sh7FFF),
            pixel_row(16'sd100), pixel_row(16'sh7FFF), pixel_row(16'sd0),
            pixel_row(16'sh7FFF),
            closing_row(16'sh7FFF, t_pool_result'{16'sh7FFF, 4'd5, 6'd1, 7'd0, 7'd0, 1'b0}),
            pixel_row(16'sd0),
            pixel_row(16'sd1), pixel_row(16'sd2), pixel_row(16'sd3),
            write_row(CFG_UNUSED, 9'h1FF),
            pixel_row(16'sd4),
            closing_row(16'sd9, t_pool_result'{16'sd9, 4'd8, 6'd2, 7'd0, 7'd0, 1'b0}),
            pixel_row(16'sd6),
            write_row(CFG_CHANNEL_COUNT, 9'h180),
            pixel_row(-16'sd1), pixel_row(-16'sd2), pixel_row(16'sd7),
            pixel_row(-16'sd3),
            closing_row(16'sd0, t_pool_result'{16'sd0, 4'd8, 6'd0, 7'd0, 7'd0, 1'b1}),
            pixel_row(-16'sd5)
        };

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++) begin
            if (directed_rows[k].kind == ROW_WRITE) begin
                wait_drained();
                write_reg(directed_rows[k].reg_index, directed_rows[k].reg_data);
            end else begin
                push_pixel(directed_rows[k].pixel, directed_rows[k].has_want,
                           directed_rows[k].want);
            end
        end

        // Mostly whole maps of small random shapes; some are cut short or run over.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            hd = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 1)) : 9'($urandom_range(2, 8));
            wd = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 1)) : 9'($urandom_range(2, 8));
            cd = ($urandom_range(0, 7) == 0) ? 9'd0 : 9'($urandom_range(1, 4));
            wait_drained();
            set_map_shape(hd, wd, cd);
            count = map_pixels();
            if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count + count / 2);
            run_map(count);
            random_items += count;
        end

        // The output side holds off while pixels keep coming, so the input must stall.
        idle_on = 1'b1;
        wait_drained();
        set_map_shape(9'd2, 9'd2, 9'd16);
        hold_request = 1'b1;
        run_map(map_pixels());

        // Channel count above the limit, with no idling on either side.
        idle_on = 1'b0;
        wait_drained();
        set_map_shape(9'd2, 9'd2, 9'd100);
        run_map(map_pixels());

        wait_drained();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/mpool_pkg.sv
hdl/mpool_cell.sv
hdl/mpool_line_buf.sv
hdl/mpool_out_fifo.sv
hdl/max_pool_3x3_stride2_argmax_core.sv
tb/sv/max_pool_3x3_stride2_argmax_core_tb.sv
